[rtl/core/ppic_pkg.sv]
// ----------------------------------------------------------------------------
// ppic_pkg
// Shared types and constants of the patch pressure influence coefficient unit.
// ----------------------------------------------------------------------------
package ppic_pkg;

  // signed grid offsets after adding or removing a half width
  localparam int OFS_W = 9;
  // signed Q28 log sum
  localparam int LG_W  = 35;

  // ln 2 in Q30 and pi in Q29
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [30:0] PI_Q29  = 31'd1686629713;
  // floor(2^62 / pi in Q29), reciprocal for the final scaling by 1/pi
  localparam logic [31:0] PI_RECIP = 32'((64'd1 << 62) / 64'(PI_Q29));

  // register indexes on the configuration port
  localparam logic [1:0] REG_HALF_X  = 2'd0;
  localparam logic [1:0] REG_HALF_Y  = 2'd1;
  localparam logic [1:0] REG_MODULUS = 2'd2;

  // classified word passed from the front end to the back end
  typedef struct packed {
    logic signed [OFS_W-1:0] xp;
    logic signed [OFS_W-1:0] xm;
    logic signed [OFS_W-1:0] yp;
    logic signed [OFS_W-1:0] ym;
    logic [15:0]             load;
  } item_t;

  // request to the log sum unit
  typedef struct packed {
    logic                    start;
    logic signed [OFS_W-1:0] u;
    logic signed [OFS_W-1:0] v;
  } lg_req_t;

  // response from the log sum unit
  typedef struct packed {
    logic                   idle;
    logic                   done;
    logic signed [LG_W-1:0] result;
  } lg_rsp_t;

endpackage

[rtl/core/ppic_front.sv]
// ----------------------------------------------------------------------------
// ppic_front
// Accepts offset words and forms the four leading offsets x+a, x-a, y+b, y-b.
// ----------------------------------------------------------------------------
module ppic_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  logic signed [6:0] offset_x,
  input  logic signed [6:0] offset_y,
  input  logic [15:0]       load,
  input  logic [6:0]        half_width_x,
  input  logic [6:0]        half_width_y,
  output logic              push_valid,
  output ppic_pkg::item_t   push_item,
  input  logic              push_ready
);
  import ppic_pkg::*;

  logic                    vld;
  item_t                   held;
  logic signed [OFS_W-1:0] x_ext;
  logic signed [OFS_W-1:0] y_ext;
  logic signed [OFS_W-1:0] a_ext;
  logic signed [OFS_W-1:0] b_ext;

  // sign extend offsets, zero extend half widths
  assign x_ext = {{2{offset_x[6]}}, offset_x};
  assign y_ext = {{2{offset_y[6]}}, offset_y};
  assign a_ext = {2'b00, half_width_x};
  assign b_ext = {2'b00, half_width_y};

  assign item_ready = !vld || push_ready;
  assign push_valid = vld;
  assign push_item  = held;

  // single holding stage in front of the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (item_valid && item_ready) begin
      vld       <= 1'b1;
      held.xp   <= x_ext + a_ext;
      held.xm   <= x_ext - a_ext;
      held.yp   <= y_ext + b_ext;
      held.ym   <= y_ext - b_ext;
      held.load <= load;
    end else if (push_ready) begin
      vld <= 1'b0;
    end
  end

endmodule

[rtl/core/ppic_fifo.sv]
// ----------------------------------------------------------------------------
// ppic_fifo
// Short queue of classified words between the front end and the back end.
// ----------------------------------------------------------------------------
module ppic_fifo #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  input  ppic_pkg::item_t push_item,
  output logic            push_ready,
  output logic            pop_valid,
  output ppic_pkg::item_t pop_item,
  input  logic            pop_ready
);
  import ppic_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = store[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/core/ppic_lgsum.sv]
// ----------------------------------------------------------------------------
// ppic_lgsum
// Iterative ln(u + sqrt(u*u + v*v)) in Q28: bit-serial square root, then a
// log2 by repeated squaring, one bit a cycle, scaled by ln 2.
// ----------------------------------------------------------------------------
module ppic_lgsum (
  input  logic              clk,
  input  logic              rst,
  input  ppic_pkg::lg_req_t req,
  output ppic_pkg::lg_rsp_t rsp
);
  import ppic_pkg::*;

  typedef enum logic [4:0] {
    LG_IDLE  = 5'b00001,
    LG_SQRT  = 5'b00010,
    LG_NORM  = 5'b00100,
    LG_LOG   = 5'b01000,
    LG_SCALE = 5'b10000
  } lg_state_t;

  lg_state_t              state;
  logic [7:0]             au;
  logic [7:0]             av;
  logic                   u_neg;
  logic [16:0]            nsq;
  logic [24:0]            root;
  logic [4:0]             idx;
  logic [30:0]            m;
  logic [3:0]             shift;
  logic [27:0]            frac;
  logic [4:0]             step;
  logic                   pass;
  logic [31:0]            ln1;
  logic signed [LG_W-1:0] result;
  logic                   done;

  logic signed [OFS_W-1:0] u_abs;
  logic signed [OFS_W-1:0] v_abs;
  logic [15:0]             sq_u;
  logic [15:0]             sq_v;
  logic [24:0]             trial;
  logic [49:0]             trial_sq;
  logic                    fits;
  logic [24:0]             root_next;
  logic [25:0]             w_sum;
  logic [61:0]             m_sq;
  logic [31:0]             mm;
  logic [31:0]             lg;
  logic [61:0]             lg_ln;
  logic [31:0]             ln;
  logic signed [LG_W-1:0]  combined;

  // mantissa start value, with a floor of 1.0
  function automatic logic [30:0] norm_start(input logic [25:0] w);
    logic [30:0] r;
    r = (w[25:16] == '0) ? 31'h10000 : {5'b0, w};
    return r;
  endfunction

  // operand magnitudes
  assign u_abs = req.u[OFS_W-1] ? -req.u : req.u;
  assign v_abs = req.v[OFS_W-1] ? -req.v : req.v;
  assign sq_u  = u_abs[7:0] * u_abs[7:0];
  assign sq_v  = v_abs[7:0] * v_abs[7:0];

  // square root trial bit
  assign trial     = root | (25'd1 << idx);
  assign trial_sq  = trial * trial;
  assign fits      = (trial_sq <= {1'b0, nsq, 32'b0});
  assign root_next = fits ? trial : root;
  assign w_sum     = {2'b00, au, 16'b0} + {1'b0, root_next};

  // one squaring step of the mantissa
  assign m_sq = m * m;
  assign mm   = m_sq[61:30];

  // log2 to natural log
  assign lg       = {4'd14 - shift, frac};
  assign lg_ln    = lg * LN2_Q30;
  assign ln       = lg_ln[61:30];
  assign combined = $signed({2'b00, ln, 1'b0}) - $signed({3'b000, ln1});

  assign rsp.idle   = (state == LG_IDLE);
  assign rsp.done   = done;
  assign rsp.result = result;

  // completion pulse as the last scaling step ends
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == LG_SCALE) && (pass || !u_neg);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LG_IDLE;
    end else begin
      unique case (state)
        LG_IDLE: begin
          if (req.start) begin
            au    <= u_abs[7:0];
            av    <= v_abs[7:0];
            u_neg <= req.u[OFS_W-1];
            nsq   <= {1'b0, sq_u} + {1'b0, sq_v};
            root  <= '0;
            idx   <= 5'd24;
            pass  <= 1'b0;
            state <= LG_SQRT;
          end
        end
        LG_SQRT: begin
          root <= root_next;
          if (idx == '0) begin
            m     <= norm_start(w_sum);
            shift <= '0;
            state <= LG_NORM;
          end else begin
            idx <= idx - 1'b1;
          end
        end
        LG_NORM: begin
          if (m[30]) begin
            step  <= '0;
            state <= LG_LOG;
          end else begin
            m     <= {m[29:0], 1'b0};
            shift <= shift + 1'b1;
          end
        end
        LG_LOG: begin
          m    <= mm[31] ? mm[31:1] : mm[30:0];
          frac <= {frac[26:0], mm[31]};
          if (step == 5'd27) begin
            state <= LG_SCALE;
          end else begin
            step <= step + 1'b1;
          end
        end
        LG_SCALE: begin
          if (!pass) begin
            ln1 <= ln;
            if (u_neg) begin
              // negative u: 2 ln|v| - ln(|u| + sqrt)
              pass  <= 1'b1;
              m     <= norm_start({2'b00, av, 16'b0});
              shift <= '0;
              state <= LG_NORM;
            end else begin
              result <= $signed({3'b000, ln});
              state  <= LG_IDLE;
            end
          end else begin
            result <= combined;
            state  <= LG_IDLE;
          end
        end
        default: state <= LG_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/ppic_engine.sv]
// ----------------------------------------------------------------------------
// ppic_engine
// Back end: sums the four log terms, scales by load over the modulus with a
// bit-serial divider, then by 1/pi with a reciprocal multiply, saturates and
// holds the result word.
// ----------------------------------------------------------------------------
module ppic_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               pop_valid,
  input  ppic_pkg::item_t    pop_item,
  output logic               pop_ready,
  input  logic [15:0]        modulus,
  output ppic_pkg::lg_req_t  lg_req,
  input  ppic_pkg::lg_rsp_t  lg_rsp,
  output logic               result_valid,
  input  logic               result_ready,
  output logic signed [31:0] deflection
);
  import ppic_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE    = 17'b00000000000000001,
    S_TSEL    = 17'b00000000000000010,
    S_CALL    = 17'b00000000000000100,
    S_WAIT    = 17'b00000000000001000,
    S_TERM    = 17'b00000000000010000,
    S_MAG     = 17'b00000000000100000,
    S_MUL_LO  = 17'b00000000001000000,
    S_MUL_HI  = 17'b00000000010000000,
    S_DIV     = 17'b00000000100000000,
    S_CHK     = 17'b00000001000000000,
    S_RCP_LO  = 17'b00000010000000000,
    S_RCP_HI  = 17'b00000100000000000,
    S_BACK_LO = 17'b00001000000000000,
    S_BACK_HI = 17'b00010000000000000,
    S_RESID   = 17'b00100000000000000,
    S_FIX     = 17'b01000000000000000,
    S_SAT     = 17'b10000000000000000
  } eng_state_t;

  localparam logic [5:0] DIV_LAST = 6'd62;

  eng_state_t             state;
  item_t                  item;
  logic signed [47:0]     acc;
  logic [1:0]             k;
  logic                   h;
  logic signed [LG_W-1:0] ln_n;
  logic signed [LG_W-1:0] ln_d;
  logic                   neg;
  logic [46:0]            mag;
  logic [62:0]            num;
  logic [30:0]            den;
  logic [30:0]            rem;
  logic [5:0]             cnt;
  logic                   sat;
  logic [45:0]            qv;
  logic [77:0]            rcp;
  logic [32:0]            quo;
  logic [63:0]            rprod;
  logic [33:0]            resid;

  logic signed [OFS_W-1:0] t_sel;
  logic signed [OFS_W-1:0] nu_sel;
  logic signed [OFS_W-1:0] du_sel;
  logic signed [LG_W:0]    diff;
  logic signed [44:0]      term_prod;
  logic signed [47:0]      acc_neg;
  logic [39:0]             lo_prod;
  logic [38:0]             hi_prod;
  logic [31:0]             rem_sh;
  logic [31:0]             rem_sub;
  logic                    ge;
  logic [15:0]             divisor;
  logic [54:0]             rcp_lo;
  logic [54:0]             rcp_hi;
  logic [47:0]             back_lo;
  logic [46:0]             back_hi;
  logic [63:0]             resid_full;
  logic [31:0]             pos_val;
  logic [31:0]             neg_val;
  logic                    take;

  // operands of the current term
  always_comb begin
    unique case (k)
      2'd0: begin t_sel = item.xp; nu_sel = item.yp; du_sel = item.ym; end
      2'd1: begin t_sel = item.yp; nu_sel = item.xp; du_sel = item.xm; end
      2'd2: begin t_sel = item.xm; nu_sel = item.ym; du_sel = item.yp; end
      default: begin t_sel = item.ym; nu_sel = item.xm; du_sel = item.xp; end
    endcase
  end

  assign pop_ready    = (state == S_IDLE);
  assign lg_req.start = (state == S_CALL);
  assign lg_req.u     = h ? du_sel : nu_sel;
  assign lg_req.v     = t_sel;

  // term product and magnitude
  assign diff      = (LG_W+1)'(ln_n) - (LG_W+1)'(ln_d);
  assign term_prod = t_sel * diff;
  assign acc_neg   = -acc;
  assign lo_prod   = mag[23:0] * item.load;
  assign hi_prod   = mag[46:24] * item.load;

  // restoring divide step by the modulus
  assign rem_sh  = {rem, num[62]};
  assign ge      = (rem_sh >= {1'b0, den});
  assign rem_sub = rem_sh - {1'b0, den};
  assign divisor = (modulus == '0) ? 16'd1 : modulus;

  // quotient estimate by the reciprocal of pi, then back product and residue
  assign rcp_lo     = qv[22:0] * PI_RECIP;
  assign rcp_hi     = qv[45:23] * PI_RECIP;
  assign back_lo    = rcp[61:45] * PI_Q29;
  assign back_hi    = quo[32:17] * PI_Q29;
  assign resid_full = {1'b0, qv, 17'b0} - rprod;

  // saturation by sign
  assign pos_val = (sat || (quo[32:31] != '0)) ? 32'h7FFFFFFF : quo[31:0];
  assign neg_val = (sat || (quo > 33'h080000000)) ? 32'h80000000 : (32'd0 - quo[31:0]);
  assign take    = !result_valid || result_ready;

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready && (state != S_SAT)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop_valid) begin
            item  <= pop_item;
            acc   <= '0;
            k     <= '0;
            state <= S_TSEL;
          end
        end
        S_TSEL: begin
          if (t_sel == '0) begin
            // zero leading offset: term is skipped
            if (k == 2'd3) begin
              state <= S_MAG;
            end else begin
              k <= k + 1'b1;
            end
          end else begin
            h     <= 1'b0;
            state <= S_CALL;
          end
        end
        S_CALL: state <= S_WAIT;
        S_WAIT: begin
          if (lg_rsp.done) begin
            if (!h) begin
              ln_n  <= lg_rsp.result;
              h     <= 1'b1;
              state <= S_CALL;
            end else begin
              ln_d  <= lg_rsp.result;
              state <= S_TERM;
            end
          end
        end
        S_TERM: begin
          acc <= acc + 48'(term_prod);
          if (k == 2'd3) begin
            state <= S_MAG;
          end else begin
            k     <= k + 1'b1;
            state <= S_TSEL;
          end
        end
        S_MAG: begin
          neg   <= acc[47];
          mag   <= acc[47] ? acc_neg[46:0] : acc[46:0];
          state <= S_MUL_LO;
        end
        S_MUL_LO: begin
          num   <= 63'(lo_prod);
          state <= S_MUL_HI;
        end
        S_MUL_HI: begin
          num   <= num + (63'(hi_prod) << 24);
          den   <= {15'b0, divisor};
          rem   <= '0;
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= ge ? rem_sub[30:0] : rem_sh[30:0];
          num <= {num[61:0], ge};
          if (cnt == DIV_LAST) begin
            state <= S_CHK;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_CHK: begin
          if (num[62:46] != '0) begin
            sat   <= 1'b1;
            state <= S_SAT;
          end else begin
            sat   <= 1'b0;
            qv    <= num[45:0];
            state <= S_RCP_LO;
          end
        end
        S_RCP_LO: begin
          rcp   <= 78'(rcp_lo);
          state <= S_RCP_HI;
        end
        S_RCP_HI: begin
          rcp   <= rcp + (78'(rcp_hi) << 23);
          state <= S_BACK_LO;
        end
        S_BACK_LO: begin
          quo   <= rcp[77:45];
          rprod <= 64'(back_lo);
          state <= S_BACK_HI;
        end
        S_BACK_HI: begin
          rprod <= rprod + (64'(back_hi) << 17);
          state <= S_RESID;
        end
        S_RESID: begin
          resid <= resid_full[33:0];
          state <= S_FIX;
        end
        S_FIX: begin
          // estimate is low by at most two
          if (resid >= {3'b000, PI_Q29}) begin
            quo   <= quo + 1'b1;
            resid <= resid - {3'b000, PI_Q29};
          end else begin
            state <= S_SAT;
          end
        end
        S_SAT: begin
          if (take) begin
            deflection   <= neg ? $signed(neg_val) : $signed(pos_val);
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    lg_req.start |-> lg_rsp.idle)
    else $error("log unit started while busy");
  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    lg_rsp.done |-> (state == S_WAIT))
    else $error("log result arrived outside wait");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    (pop_valid && pop_ready) |=> (state == S_TSEL))
    else $error("popped word not taken into term selection");
`endif

endmodule

[rtl/core/patch_pressure_influence_coefficient_unit.sv]
// ----------------------------------------------------------------------------
// patch_pressure_influence_coefficient_unit
// Deflection influence of a uniformly loaded rectangular patch, Q16.16 out.
// ----------------------------------------------------------------------------
// Each offset word is worked on in the back end: no log sum at all when every
// leading offset is zero, else up to eight log sums on one shared unit (square
// root, normalise, squaring and scaling steps per log, two logs where the lower
// bound is negative), a bit-serial divide by the modulus and a reciprocal
// multiply by 1/pi. The front end takes one word a cycle until the queue of
// QUEUE_DEPTH words and its holding stage are full; a finished word waits in
// the output register while the next one is worked on. There is no clearing
// pass after reset.
module patch_pressure_influence_coefficient_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic signed [6:0]  offset_x,
  input  logic signed [6:0]  offset_y,
  input  logic [15:0]        load,
  output logic               result_valid,
  input  logic               result_ready,
  output logic signed [31:0] deflection,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import ppic_pkg::*;

  logic [6:0]  half_width_x;
  logic [6:0]  half_width_y;
  logic [15:0] modulus;
  logic        push_valid;
  item_t       push_item;
  logic        push_ready;
  logic        pop_valid;
  item_t       pop_item;
  logic        pop_ready;
  lg_req_t     lg_req;
  lg_rsp_t     lg_rsp;

  assign pready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      half_width_x <= 7'd5;
      half_width_y <= 7'd5;
      modulus      <= 16'd256;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_HALF_X:  half_width_x <= pwdata[6:0];
        REG_HALF_Y:  half_width_y <= pwdata[6:0];
        REG_MODULUS: modulus      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[3:2])
      REG_HALF_X:  prdata = {25'b0, half_width_x};
      REG_HALF_Y:  prdata = {25'b0, half_width_y};
      REG_MODULUS: prdata = {16'b0, modulus};
      default:     prdata = '0;
    endcase
  end

  ppic_front u_front (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .offset_x     (offset_x),
    .offset_y     (offset_y),
    .load         (load),
    .half_width_x (half_width_x),
    .half_width_y (half_width_y),
    .push_valid   (push_valid),
    .push_item    (push_item),
    .push_ready   (push_ready)
  );

  ppic_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  ppic_lgsum u_lgsum (
    .clk (clk),
    .rst (rst),
    .req (lg_req),
    .rsp (lg_rsp)
  );

  ppic_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_item     (pop_item),
    .pop_ready    (pop_ready),
    .modulus      (modulus),
    .lg_req       (lg_req),
    .lg_rsp       (lg_rsp),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .deflection   (deflection)
  );

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Regression bench for the patch pressure influence coefficient unit: offset
// words are pushed in bursts under a stalling result side, each deflection is
// predicted in fixed point and compared in order, over several register sets.
// ----------------------------------------------------------------------------
module tb_top;
  import ppic_pkg::*;

  // in-order store of predicted deflections with its own register copy
  class deflection_board;
    int unsigned     half_x, half_y, modul;
    logic [31:0]     pending[$];
    int unsigned     failures;

    function new();
      half_x = 5;
      half_y = 5;
      modul = 256;
      failures = 0;
    endfunction

    // integer square root, bit by bit
    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // natural log of a Q16 value, Q28 out
    function longint ln_q28(longint unsigned w);
      int top;
      longint unsigned m, frac, lg;
      top = 0;
      frac = 0;
      if (w < 65536) w = 65536;
      for (int i = 0; i < 64; i++)
        if (w[i]) top = i;
      m = (top <= 30) ? (w << (30 - top)) : (w >> (top - 30));
      for (int i = 0; i < 28; i++) begin
        m = (m * m) >> 30;
        frac <<= 1;
        if (m >= (64'd1 << 31)) begin
          m >>= 1;
          frac |= 1;
        end
      end
      lg = (longint'(top - 16) << 28) | frac;
      return longint'((lg * 64'(LN2_Q30)) >> 30);
    endfunction

    // ln(u + sqrt(u^2 + v^2)), negative u through v^2 / (sqrt - u)
    function longint log_sum(int u, int v);
      longint unsigned au, av, s;
      au = (u < 0) ? -u : u;
      av = (v < 0) ? -v : v;
      s = int_sqrt((au * au + av * av) << 32);
      if (u >= 0) return ln_q28((au << 16) + s);
      return 2 * ln_q28(av << 16) - ln_q28((au << 16) + s);
    endfunction

    function longint log_term(int t, int nu, int du, int v);
      if (t == 0) return 0;
      return longint'(t) * (log_sum(nu, v) - log_sum(du, v));
    endfunction

    function logic [31:0] deflection_of(int x, int y, int unsigned ld);
      int xp, xm, yp, ym;
      longint sum;
      longint unsigned mag, q, r, e;
      bit neg;
      xp = x + int'(half_x);
      xm = x - int'(half_x);
      yp = y + int'(half_y);
      ym = y - int'(half_y);
      sum = log_term(xp, yp, ym, xp) + log_term(yp, xp, xm, yp)
          + log_term(xm, ym, yp, xm) + log_term(ym, xm, xp, ym);
      neg = sum < 0;
      mag = neg ? -sum : sum;
      e = (modul == 0) ? 1 : modul;
      q = mag * ld / e;
      if (q >= (64'd1 << 46)) r = 64'd1 << 32;
      else r = (q << 17) / 64'(PI_Q29);
      // saturate by sign
      if (neg) begin
        if (r > 64'h8000_0000) r = 64'h8000_0000;
        return 32'(0 - r);
      end
      if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
      return r[31:0];
    endfunction

    function void note_word(int x, int y, int unsigned ld);
      pending.push_back(deflection_of(x, y, ld));
    endfunction

    function void check_word(logic [31:0] got);
      logic [31:0] want;
      if (pending.size() == 0) begin
        $display("%0t unexpected deflection %h", $time, got);
        failures++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $display("%0t deflection mismatch: expected %h actual %h", $time, want, got);
        failures++;
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_WAIT  = 1200;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_ready;
  logic signed [6:0]  offset_x = '0;
  logic signed [6:0]  offset_y = '0;
  logic [15:0]        load = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  logic signed [31:0] deflection;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  deflection_board board = new();
  int unsigned     cycles = 0;
  int unsigned     stall_mode = 0;
  int unsigned     sent = 0;

  patch_pressure_influence_coefficient_unit uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready),
    .offset_x(offset_x), .offset_y(offset_y), .load(load),
    .result_valid(result_valid), .result_ready(result_ready),
    .deflection(deflection),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // accepted words on both sides
  always @(posedge clk) begin
    if (!rst && item_valid && item_ready)
      board.note_word(int'(offset_x), int'(offset_y), 32'(load));
    if (!rst && result_valid && result_ready)
      board.check_word(deflection);
  end

  // receiver stall pattern, switching style at random
  always @(posedge clk) begin
    if (cycles % 256 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: result_ready <= 1'b1;
      1: result_ready <= ($urandom_range(0, 3) != 0);
      2: result_ready <= ((cycles / 40) % 2 == 0);
      default: result_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // register write, setup then access
  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // wait on the clock first so the word accepted last is already noted
  task automatic wait_drained();
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // new register set, only with the unit idle
  task automatic set_patch(int unsigned hx, int unsigned hy, int unsigned e);
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    reg_write(REG_HALF_X, hx);
    reg_write(REG_HALF_Y, hy);
    reg_write(REG_MODULUS, e);
    board.half_x = hx;
    board.half_y = hy;
    board.modul = e;
  endtask

  // hold one word until taken; valid is left high for the next one
  task automatic send_word(int x, int y, int unsigned ld);
    item_valid <= 1'b1;
    offset_x <= 7'(x);
    offset_y <= 7'(y);
    load <= 16'(ld);
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sent++;
  endtask

  task automatic random_words(int n);
    int burst;
    int x, y;
    int unsigned ld;
    while (n > 0) begin
      burst = $urandom_range(1, 8);
      while (burst > 0 && n > 0) begin
        x = $urandom_range(0, 126) - 63;
        y = $urandom_range(0, 126) - 63;
        // small offsets near the patch edges now and then
        if ($urandom_range(0, 3) == 0) begin
          x = $urandom_range(0, 20) - 10;
          y = $urandom_range(0, 20) - 10;
        end
        ld = $urandom_range(0, 3) == 0 ? $urandom_range(65000, 65535)
                                        : $urandom_range(0, 65535);
        send_word(x, y, ld);
        burst--;
        n--;
        // one full pause mid stream
        if (sent == 60) begin
          item_valid <= 1'b0;
          wait_drained();
        end
      end
      if ($urandom_range(0, 2) != 0) begin
        item_valid <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
    item_valid <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed words at reset settings: extremes, zero leading offsets
    send_word(0, 0, 256);
    send_word(63, 63, 65535);
    send_word(-63, -63, 65535);
    send_word(63, -63, 1);
    send_word(-63, 63, 0);
    send_word(5, 0, 256);
    send_word(-5, 5, 256);
    send_word(5, -5, 4096);
    send_word(0, 5, 65535);
    send_word(-1, 1, 32768);
    item_valid <= 1'b0;
    random_words(70);

    // smallest nonzero patch, smallest nonzero modulus
    set_patch(1, 1, 1);
    send_word(1, 1, 65535);
    send_word(-1, 0, 65535);
    send_word(0, 0, 65535);
    item_valid <= 1'b0;
    random_words(70);

    // large square patch, largest modulus
    set_patch(64, 64, 65535);
    send_word(63, -63, 65535);
    send_word(-63, 0, 1);
    item_valid <= 1'b0;
    random_words(70);

    // zero half widths and zero modulus
    set_patch(0, 0, 0);
    send_word(0, 0, 65535);
    send_word(0, 7, 100);
    item_valid <= 1'b0;
    random_words(70);

    // full-width x half size, uneven patch
    set_patch(127, 3, 16'h8000);
    random_words(60);

    set_patch(17, 42, 300);
    random_words(50);

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (board.failures == 0 && board.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
